// File: rtl/dds_pkg.sv
// Shared types and constants for the DDS waveform generator.
package dds_pkg;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam int INC_W      = 32;
  localparam int INDEX_W    = 16;
  localparam int LEN_W      = 17;

  localparam logic [LEN_W-1:0]      LEN_MIN   = LEN_W'(1);
  localparam logic [LEN_W-1:0]      LEN_MAX   = LEN_W'(65536);
  localparam logic [LEN_W-1:0]      LEN_RESET = LEN_W'(512);
  localparam logic [INC_W-1:0]      INC_RESET = INC_W'(32'h4000_0000);

  localparam longint unsigned Q30_ONE     = 64'd1 << 30;
  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

  typedef enum logic [1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_TRIANGLE = 2'd1,
    WAVE_SAWTOOTH = 2'd2,
    WAVE_MIDSCALE = 2'd3
  } waveform_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_WAVEFORM  = 2'd0,
    REG_PHASE_INC = 2'd1,
    REG_BUF_LEN   = 2'd2
  } cfg_reg_e;

endpackage

// File: rtl/dds_intf.sv
// Handshake interfaces for the DDS request, sample and configuration channels.
interface dds_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface dds_smp_if #(
  parameter int SAMPLE_BITS = 12
);
  logic                         valid;
  logic                         ready;
  logic [SAMPLE_BITS-1:0]       dac_sample;
  logic [dds_pkg::INDEX_W-1:0]  sample_index;
  logic                         buffer_last;

  modport source (output valid, output dac_sample, output sample_index, output buffer_last,
                  input ready);
  modport sink   (input valid, input dac_sample, input sample_index, input buffer_last,
                  output ready);
endinterface

interface dds_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [dds_pkg::CFG_ADDR_W-1:0] index;
  logic [dds_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/dds_waveform_generator_core.sv
// DDS waveform generator: phase accumulator, quarter-wave sine ROM, triangle, sawtooth and midscale.
// An accepted request word passes through the phase, ROM/waveform and sine-assembly registers to the output.
// Throughput: one sample per cycle while the output is ready; the phase and sample counters step per accepted word.
// Each stage holds its word until the next frees, so a stalled output admits words until every stage is full.
// Reset clears the pipeline, phase and counter, and loads the register defaults.
module dds_waveform_generator_core #(
  parameter int PHASE_BITS         = 32,
  parameter int SINE_TABLE_ENTRIES = 1024,
  parameter int SAMPLE_BITS        = 12
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  dds_req_if.sink      req_i,
  dds_smp_if.source    smp_o,
  dds_cfg_if.sink      cfg_i
);
  import dds_pkg::*;

  localparam int QS     = PHASE_BITS - 2;
  localparam int ADDR_W = $clog2(SINE_TABLE_ENTRIES + 1);
  localparam int PROD_W = QS + 1 + ADDR_W;
  localparam int SUM_W  = (PHASE_BITS > INC_W) ? PHASE_BITS : INC_W;
  localparam int CODE_W = SAMPLE_BITS + 1;
  localparam int WIDE_W = PHASE_BITS + CODE_W;

  localparam logic [CODE_W-1:0] MID_CODE = CODE_W'(1) << (SAMPLE_BITS - 1);
  localparam logic [CODE_W-1:0] MAX_CODE = (CODE_W'(1) << SAMPLE_BITS) - CODE_W'(1);
  localparam logic [QS:0]       QUAD     = (QS + 1)'(1) << QS;

  typedef logic [SAMPLE_BITS-1:0] rom_t [SINE_TABLE_ENTRIES+1];

  // Q30 odd polynomial for sin over the first quadrant, rounded to half scale
  function automatic rom_t build_rom();
    rom_t            rom;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned f;
    longint unsigned s;
    longint unsigned v;
    longint unsigned mid;
    mid = 64'd1 << (SAMPLE_BITS - 1);
    for (int k = 0; k <= SINE_TABLE_ENTRIES; k++) begin
      x  = (PI_HALF_Q30 * 64'(k)) / SINE_TABLE_ENTRIES;
      x2 = (x * x) >> 30;
      f  = Q30_ONE - x2 / 110;
      f  = Q30_ONE - ((x2 * f) >> 30) / 72;
      f  = Q30_ONE - ((x2 * f) >> 30) / 42;
      f  = Q30_ONE - ((x2 * f) >> 30) / 20;
      f  = Q30_ONE - ((x2 * f) >> 30) / 6;
      s  = (x * f) >> 30;
      v  = (s * mid + (Q30_ONE >> 1)) >> 30;
      if (v > mid) begin
        v = mid;
      end
      rom[k] = SAMPLE_BITS'(v);
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  // configuration registers
  waveform_e         sel_q;
  logic [INC_W-1:0]  inc_q;
  logic [LEN_W-1:0]  len_q;
  logic [LEN_W-1:0]  len_wr;

  // generator state
  logic [PHASE_BITS-1:0] phase_q, phase_d;
  logic [INDEX_W-1:0]    cnt_q, cnt_d;

  // pipeline
  logic                   v1_q, v2_q, v3_q;
  logic                   en1, en2, en3;
  logic [PHASE_BITS-1:0]  p1_q;
  logic [INDEX_W-1:0]     idx1_q, idx2_q, idx3_q;
  logic                   last1_q, last2_q, last3_q;
  waveform_e              sel1_q, sel2_q;
  logic                   neg2_q;
  logic [SAMPLE_BITS-1:0] rom2_q;
  logic [SAMPLE_BITS-1:0] alt2_q, alt_d;
  logic [SAMPLE_BITS-1:0] dac3_q, dac_d;

  logic                  acc;
  logic [PHASE_BITS-1:0] ph_use;
  logic [INDEX_W-1:0]    cnt_use;
  logic [LEN_W-1:0]      cnt_inc;
  logic                  last_w;
  logic [SUM_W-1:0]      sum;

  logic [1:0]            quad;
  logic [QS:0]           rr;
  logic [PROD_W-1:0]     prod;
  logic [ADDR_W-1:0]     addr;
  logic [PHASE_BITS-1:0] m, m1;
  logic [WIDE_W-1:0]     wide_p, wide_m, wide_m1;
  logic [CODE_W-1:0]     sc_p, sc_m, sc_m1, tri_code;
  logic [CODE_W-1:0]     sine_code;

  // configuration port
  assign cfg_i.ready = 1'b1;

  always_comb begin
    len_wr = cfg_i.data[LEN_W-1:0];
    if (len_wr == '0) begin
      len_wr = LEN_MIN;
    end else if (len_wr > LEN_MAX) begin
      len_wr = LEN_MAX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= WAVE_SINE;
      inc_q <= INC_RESET;
      len_q <= LEN_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_WAVEFORM:  sel_q <= waveform_e'(cfg_i.data[1:0]);
        REG_PHASE_INC: inc_q <= cfg_i.data[INC_W-1:0];
        REG_BUF_LEN:   len_q <= len_wr;
        default: ;
      endcase
    end
  end

  // handshake: each stage moves when the next one is empty or moving
  assign en3         = !v3_q || smp_o.ready;
  assign en2         = !v2_q || en3;
  assign en1         = !v1_q || en2;
  assign req_i.ready = en1;
  assign acc         = req_i.valid && en1;

  // phase and counter step
  always_comb begin
    ph_use  = req_i.restart ? '0 : phase_q;
    cnt_use = req_i.restart ? '0 : cnt_q;
    cnt_inc = LEN_W'(cnt_use) + LEN_W'(1);
    last_w  = cnt_inc >= len_q;
    sum     = SUM_W'(ph_use) + SUM_W'(inc_q);
    phase_d = last_w ? '0 : sum[PHASE_BITS-1:0];
    cnt_d   = last_w ? '0 : cnt_inc[INDEX_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      cnt_q   <= '0;
    end else if (acc) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  // stage 2 address, triangle and sawtooth
  always_comb begin
    quad = p1_q[PHASE_BITS-1 -: 2];
    rr   = quad[0] ? QUAD - {1'b0, p1_q[QS-1:0]} : {1'b0, p1_q[QS-1:0]};
    prod = PROD_W'(rr) * PROD_W'(SINE_TABLE_ENTRIES);
    addr = prod[QS +: ADDR_W];

    m       = -p1_q;
    m1      = m - PHASE_BITS'(1);
    wide_p  = {p1_q, {CODE_W{1'b0}}};
    wide_m  = {m, {CODE_W{1'b0}}};
    wide_m1 = {m1, {CODE_W{1'b0}}};
    sc_p    = wide_p[PHASE_BITS +: CODE_W];
    sc_m    = wide_m[PHASE_BITS +: CODE_W];
    sc_m1   = wide_m1[PHASE_BITS +: CODE_W];
    tri_code = p1_q[PHASE_BITS-1] ? sc_m1 + CODE_W'(sc_m != sc_m1) : sc_p;
    if (tri_code > MAX_CODE) begin
      tri_code = MAX_CODE;
    end

    unique case (sel1_q)
      WAVE_TRIANGLE: alt_d = tri_code[SAMPLE_BITS-1:0];
      WAVE_SAWTOOTH: alt_d = p1_q[PHASE_BITS-1 -: SAMPLE_BITS];
      WAVE_SINE,
      WAVE_MIDSCALE: alt_d = MID_CODE[SAMPLE_BITS-1:0];
      default:       alt_d = MID_CODE[SAMPLE_BITS-1:0];
    endcase
  end

  // stage 3 sine assembly
  always_comb begin
    sine_code = neg2_q ? MID_CODE - CODE_W'(rom2_q) : MID_CODE + CODE_W'(rom2_q);
    if (sine_code > MAX_CODE) begin
      sine_code = MAX_CODE;
    end
    dac_d = (sel2_q == WAVE_SINE) ? sine_code[SAMPLE_BITS-1:0] : alt2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= acc;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      p1_q    <= ph_use;
      idx1_q  <= cnt_use;
      last1_q <= last_w;
      sel1_q  <= sel_q;
    end
    if (en2) begin
      rom2_q  <= SINE_ROM[addr];
      neg2_q  <= quad[1];
      alt2_q  <= alt_d;
      sel2_q  <= sel1_q;
      idx2_q  <= idx1_q;
      last2_q <= last1_q;
    end
    if (en3) begin
      dac3_q  <= dac_d;
      idx3_q  <= idx2_q;
      last3_q <= last2_q;
    end
  end

  assign smp_o.valid        = v3_q;
  assign smp_o.dac_sample   = dac3_q;
  assign smp_o.sample_index = idx3_q;
  assign smp_o.buffer_last  = last3_q;

`ifndef NO_ASSERTIONS
  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> (v1_q && v2_q && v3_q))
    else $error("request stalled with a free stage");

  a_last_wrap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && last_w) |=> (cnt_q == '0 && phase_q == '0))
    else $error("buffer end did not restart phase and counter");

  a_cnt_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && !last_w) |=> (cnt_q == $past(cnt_inc[INDEX_W-1:0])))
    else $error("sample counter did not advance by one");

  a_midscale : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en3 && v2_q && sel2_q == WAVE_MIDSCALE) |=>
      (smp_o.dac_sample == MID_CODE[SAMPLE_BITS-1:0]))
    else $error("midscale word carries wrong code");
`endif

endmodule

// File: verif/tb_dds_waveform_generator_core.sv
// Self-checking testbench for dds_waveform_generator_core: directed table, then random traffic.
module tb_dds_waveform_generator_core;
  import dds_pkg::*;

  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int LIMIT_CYCLES = 400000;

  typedef struct packed {
    logic [11:0] code;
    logic [15:0] index;
    logic        last;
  } dac_word_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [1:0]  idx;
    logic [31:0] data;
    logic        restart;
    bit          golden_on;
    dac_word_t   golden;
  } step_t;

  logic clk_i;
  logic rst_ni;

  dds_req_if                     req ();
  dds_smp_if #(.SAMPLE_BITS(12)) smp ();
  dds_cfg_if                     cfg ();

  dds_waveform_generator_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .smp_o  (smp),
    .cfg_i  (cfg)
  );

  // predictor state
  logic [11:0]      quarter_sine [0:1024];
  waveform_e        wave_sel;
  logic [INC_W-1:0] phase_step;
  logic [LEN_W-1:0] buf_len;
  logic [31:0]      phase;
  logic [15:0]      sample_cnt;

  dac_word_t pending_samples [$];
  step_t     directed [$];
  int        mismatches;
  int        cycle_count;
  int        req_idle_pct;
  int        smp_idle_pct;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  function automatic void build_quarter_sine();
    longint unsigned x, x2, f, s, v;
    for (int k = 0; k <= 1024; k++) begin
      x  = (PI_HALF_Q30 * longint'(k)) / 64'd1024;
      x2 = (x * x) >> 30;
      f  = Q30_ONE - x2 / 64'd110;
      f  = Q30_ONE - ((x2 * f) >> 30) / 64'd72;
      f  = Q30_ONE - ((x2 * f) >> 30) / 64'd42;
      f  = Q30_ONE - ((x2 * f) >> 30) / 64'd20;
      f  = Q30_ONE - ((x2 * f) >> 30) / 64'd6;
      s  = (x * f) >> 30;
      v  = (s * 64'd2048 + (Q30_ONE >> 1)) >> 30;
      if (v > 64'd2048) v = 64'd2048;
      quarter_sine[k] = v[11:0];
    end
  endfunction

  function automatic dac_word_t synth_sample(input logic restart);
    dac_word_t       w;
    logic [LEN_W-1:0] eff_len;
    longint unsigned p, r, a, c;
    eff_len = (buf_len == '0) ? LEN_MIN : (buf_len > LEN_MAX) ? LEN_MAX : buf_len;
    if (restart) begin
      phase      = '0;
      sample_cnt = '0;
    end
    p = 64'(phase);
    case (wave_sel)
      WAVE_SINE: begin
        r = 64'(phase[29:0]);
        if (phase[30]) r = (64'd1 << 30) - r;
        a = (r * 64'd1024) >> 30;
        if (a > 64'd1024) a = 64'd1024;
        c = phase[31] ? 64'd2048 - 64'(quarter_sine[a]) : 64'd2048 + 64'(quarter_sine[a]);
      end
      WAVE_TRIANGLE: c = phase[31] ? ((64'd1 << 32) - p) >> 19 : p >> 19;
      WAVE_SAWTOOTH: c = p >> 20;
      default:       c = 64'd2048;
    endcase
    if (c > 64'd4095) c = 64'd4095;
    w.code  = c[11:0];
    w.index = sample_cnt;
    w.last  = (32'(sample_cnt) + 32'd1) >= 32'(eff_len);
    if (w.last) begin
      phase      = '0;
      sample_cnt = '0;
    end else begin
      phase      = phase + phase_step;
      sample_cnt = sample_cnt + 16'd1;
    end
    return w;
  endfunction

  function automatic step_t req_row(input logic rs);
    return '{ROW_REQ, REG_WAVEFORM, 32'd0, rs, 1'b0, '0};
  endfunction

  function automatic step_t chk_row(input logic rs, input logic [11:0] code,
                                    input logic [15:0] index, input logic last);
    return '{ROW_REQ, REG_WAVEFORM, 32'd0, rs, 1'b1, '{code, index, last}};
  endfunction

  function automatic step_t cfg_row(input logic [1:0] idx, input logic [31:0] d);
    return '{ROW_CFG, idx, d, 1'b0, 1'b0, '0};
  endfunction

  // entered and left at a falling edge
  task automatic push_request(input logic rs, input bit golden_on, input dac_word_t golden);
    dac_word_t predicted;
    while ($urandom_range(99) < req_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk_i);
    end
    req.valid   <= 1'b1;
    req.restart <= rs;
    do @(posedge clk_i); while (!req.ready);
    predicted = synth_sample(rs);
    pending_samples.push_back(golden_on ? golden : predicted);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] d);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= d;
    do @(posedge clk_i); while (!cfg.ready);
    case (idx)
      REG_WAVEFORM:  wave_sel   = waveform_e'(d[1:0]);
      REG_PHASE_INC: phase_step = d;
      REG_BUF_LEN:   buf_len    = d[LEN_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic drain_pipeline();
    req.valid <= 1'b0;
    while (pending_samples.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (rst_ni) smp.ready <= ($urandom_range(99) >= smp_idle_pct);
  end

  always @(posedge clk_i) begin : sample_check
    dac_word_t want;
    if (rst_ni && smp.valid && smp.ready) begin
      if (pending_samples.size() == 0) begin
        $error("unexpected word: dac_sample %0d sample_index %0d buffer_last %0d",
               smp.dac_sample, smp.sample_index, smp.buffer_last);
        mismatches++;
      end else begin
        want = pending_samples.pop_front();
        if (smp.dac_sample !== want.code) begin
          $error("dac_sample: expected %0d, got %0d", want.code, smp.dac_sample);
          mismatches++;
        end
        if (smp.sample_index !== want.index) begin
          $error("sample_index: expected %0d, got %0d", want.index, smp.sample_index);
          mismatches++;
        end
        if (smp.buffer_last !== want.last) begin
          $error("buffer_last: expected %0d, got %0d", want.last, smp.buffer_last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    logic [31:0] d;
    logic [16:0] len_pick;
    mismatches   = 0;
    req_idle_pct = 25;
    smp_idle_pct = 84;
    build_quarter_sine();
    wave_sel    = WAVE_SINE;
    phase_step  = INC_RESET;
    buf_len     = LEN_RESET;
    phase       = '0;
    sample_cnt  = '0;
    rst_ni      = 1'b0;
    req.valid   = 1'b0;
    req.restart = 1'b0;
    cfg.valid   = 1'b0;
    cfg.index   = REG_WAVEFORM;
    cfg.data    = '0;
    smp.ready   = 1'b0;

    directed = '{
      chk_row(1'b0, 12'd2048, 16'd0, 1'b0),   // sine zero crossing
      chk_row(1'b0, 12'd4095, 16'd1, 1'b0),   // sine peak saturates
      chk_row(1'b0, 12'd2048, 16'd2, 1'b0),
      chk_row(1'b0, 12'd0,    16'd3, 1'b0),   // sine trough
      chk_row(1'b1, 12'd2048, 16'd0, 1'b0),
      cfg_row(REG_WAVEFORM, 32'(WAVE_TRIANGLE)),
      cfg_row(REG_PHASE_INC, 32'h8000_0000),
      chk_row(1'b1, 12'd0,    16'd0, 1'b0),
      chk_row(1'b0, 12'd4095, 16'd1, 1'b0),   // triangle apex saturates
      chk_row(1'b0, 12'd0,    16'd2, 1'b0),
      cfg_row(REG_WAVEFORM, 32'(WAVE_SAWTOOTH)),
      cfg_row(REG_PHASE_INC, 32'hFFFF_FFFF),
      chk_row(1'b1, 12'd0,    16'd0, 1'b0),
      chk_row(1'b0, 12'd4095, 16'd1, 1'b0),
      req_row(1'b0),
      cfg_row(REG_WAVEFORM, 32'hFFFF_FFFF),   // masks to midscale
      cfg_row(REG_BUF_LEN, 32'd1),
      chk_row(1'b0, 12'd2048, 16'd3, 1'b1),   // counter past shrunk length
      chk_row(1'b1, 12'd2048, 16'd0, 1'b1),
      cfg_row(REG_BUF_LEN, 32'd0),            // zero length acts as one
      chk_row(1'b0, 12'd2048, 16'd0, 1'b1),
      cfg_row(REG_BUF_LEN, 32'hFFFF_FFFF),    // clamps to 65536
      chk_row(1'b0, 12'd2048, 16'd0, 1'b0),
      cfg_row(REG_SPARE, 32'd1),              // unknown register, ignored
      chk_row(1'b0, 12'd2048, 16'd1, 1'b0),
      cfg_row(REG_PHASE_INC, 32'd0),
      cfg_row(REG_WAVEFORM, 32'(WAVE_SINE)),
      cfg_row(REG_BUF_LEN, 32'd3),
      req_row(1'b0),
      req_row(1'b1)
    };

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        drain_pipeline();
        write_reg(directed[i].idx, directed[i].data);
      end else begin
        push_request(directed[i].restart, directed[i].golden_on, directed[i].golden);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      req_idle_pct = (ph == 0) ? 25 : (ph == 1) ? 84 : 0;
      smp_idle_pct = (ph == 0) ? 84 : (ph == 1) ? 25 : 0;
      for (int seg = 0; seg < 4; seg++) begin
        drain_pipeline();
        d = $urandom();
        d[1:0] = 2'(seg);
        write_reg(REG_WAVEFORM, d);
        case ($urandom_range(7))
          0:       d = 32'd0;
          1:       d = 32'hFFFF_FFFF;
          2, 3:    d = $urandom_range(1, 32'h0100_0000);
          default: d = $urandom();
        endcase
        write_reg(REG_PHASE_INC, d);
        case ($urandom_range(9))
          0:       len_pick = 17'd0;
          1:       len_pick = 17'd65536;
          2:       len_pick = 17'($urandom_range(0, 17'h1FFFF));
          default: len_pick = 17'($urandom_range(1, 40));
        endcase
        d = $urandom();
        d[16:0] = len_pick;
        write_reg(REG_BUF_LEN, d);
        if ($urandom_range(2) == 0) write_reg(REG_SPARE, $urandom());
        repeat (170) push_request($urandom_range(15) == 0, 1'b0, '0);
      end
    end

    drain_pipeline();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && pending_samples.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
